/* rtl/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// opcodes, status codes, widths and the shift command that drives the cells
// ----------------------------------------------------------------------------
package ils_pkg;

    // store geometry
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);

    // transaction field widths
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int WORD_W = 32;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 5;

    // opcodes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_DROP   = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                 ins;   // open a gap at pos and load word there
        logic                 era;   // close the gap at pos
        logic [POS_W-1:0]     pos;
        logic [WORD_BITS-1:0] word;
    } t_shift_cmd;

endpackage

/* rtl/ils_cmd_if.sv */
// ----------------------------------------------------------------------------
// ils_cmd_if: command channel of the indexed list store
// valid/ready handshake carrying opcode, position and word
// ----------------------------------------------------------------------------
interface ils_cmd_if
    import ils_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;

    modport source (output valid, output opcode, output position, output word_in,
                    input ready);
    modport sink   (input valid, input opcode, input position, input word_in,
                    output ready);
endinterface

/* rtl/ils_rsp_if.sv */
// ----------------------------------------------------------------------------
// ils_rsp_if: response channel of the indexed list store
// valid/ready handshake carrying read word, status, fill count and empty flag
// ----------------------------------------------------------------------------
interface ils_rsp_if
    import ils_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_out;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  fill_count;
    logic              is_empty;

    modport source (output valid, output word_out, output status, output fill_count,
                    output is_empty, input ready);
    modport sink   (input valid, input word_out, input status, input fill_count,
                    input is_empty, output ready);
endinterface

/* rtl/ils_cell.sv */
// ----------------------------------------------------------------------------
// ils_cell: one entry of the list
// holds a word and takes the command word or a neighbour's word when the list shifts
// ----------------------------------------------------------------------------
module ils_cell
    import ils_pkg::*;
(
    input  logic                 i_clk,
    input  logic [POS_W-1:0]     i_index,
    input  t_shift_cmd           i_cmd,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    output logic [WORD_BITS-1:0] o_q
);

    logic [WORD_BITS-1:0] r_q;
    logic [WORD_BITS-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_cmd.ins && i_index == i_cmd.pos) begin
            n_q = i_cmd.word;
        end else if (i_cmd.ins && i_index > i_cmd.pos) begin
            n_q = i_left;
        end else if (i_cmd.era && i_index >= i_cmd.pos) begin
            n_q = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

/* rtl/indexed_list_store.sv */
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list of words with a fill count
// append, drop last, read, insert, erase and clear on a row of shifting cells
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  i_cmd    | in  | opcode, position, word_in                 | valid/ready
//  o_rsp    | out | word_out, status, fill_count, is_empty    | valid/ready
//
//  one command per cycle while i_cmd.ready is high; every transaction finishes
//  in the cycle it is taken, the row of cells shifting all entries in parallel
//  for insert and erase; the response appears in the cycle after the command is
//  taken, in an output register; i_cmd.ready is high while the output register
//  is empty or being emptied, so a stalled response blocks new commands only
//  synchronous reset empties the list; entry contents are not cleared
// ----------------------------------------------------------------------------
module indexed_list_store
    import ils_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ils_cmd_if.sink   i_cmd,
    ils_rsp_if.source o_rsp
);

    // fill count and output register
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_word;
    logic [ST_W-1:0]   r_status;
    logic [CNT_W-1:0]  r_fill;
    logic              r_empty;

    logic              w_fire;
    logic              w_full;
    logic [CNT_W-1:0]  w_pos;
    logic [WORD_W-1:0] w_rd;
    logic [ST_W-1:0]   w_status;
    t_shift_cmd        w_shift;

    logic [WORD_BITS-1:0] w_cell_q [DEPTH];

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_fire      = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == CNT_MAX);
    assign w_pos       = CNT_W'(i_cmd.position);

    // command decode: status, new count and the shift broadcast
    always_comb begin
        n_count       = r_count;
        w_rd          = '0;
        w_status      = ST_OK;
        w_shift.ins   = 1'b0;
        w_shift.era   = 1'b0;
        w_shift.pos   = i_cmd.position;
        w_shift.word  = i_cmd.word_in[WORD_BITS-1:0];
        case (i_cmd.opcode)
            OP_APPEND: begin
                // append is an insert at the end of the list
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_shift.ins = 1'b1;
                    w_shift.pos = POS_W'(r_count);
                    n_count     = r_count + 1'b1;
                end
            end
            OP_DROP: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_READ: begin
                if (w_pos >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd = WORD_W'(w_cell_q[i_cmd.position[IDX_W-1:0]]);
                end
            end
            OP_INSERT: begin
                // range check takes priority over full
                if (w_pos > r_count) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_shift.ins = 1'b1;
                    n_count     = r_count + 1'b1;
                end
            end
            OP_ERASE: begin
                if (w_pos >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_shift.era = 1'b1;
                    n_count     = r_count - 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused opcodes leave the list alone
            end
        endcase
        // shifts only happen on an accepted transaction
        if (!w_fire) begin
            w_shift.ins = 1'b0;
            w_shift.era = 1'b0;
        end
    end

    // row of cells, each wired to its neighbours
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WORD_BITS-1:0] w_left;
        logic [WORD_BITS-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_q[k-1];
        end

        // the last cell has nothing to its right; it keeps its own word
        if (k == DEPTH - 1) begin : g_last
            assign w_right = w_cell_q[k];
        end else begin : g_mid_r
            assign w_right = w_cell_q[k+1];
        end

        ils_cell u_cell (
            .i_clk   (i_clk),
            .i_index (POS_W'(k)),
            .i_cmd   (w_shift),
            .i_left  (w_left),
            .i_right (w_right),
            .o_q     (w_cell_q[k])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_word   <= w_rd;
            r_status <= w_status;
            r_fill   <= n_count;
            r_empty  <= (n_count == '0);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.word_out   = r_word;
    assign o_rsp.status     = r_status;
    assign o_rsp.fill_count = r_fill;
    assign o_rsp.is_empty   = r_empty;

    // the fill count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("fill count above capacity");

    // a full status only reports a full list
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_FULL |-> r_fill == CNT_MAX)
        else $error("full status with room left");

    // a failed command never returns a word
    a_fail_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_OK |-> r_word == '0)
        else $error("word returned on a failed command");

    // a clear leaves the list empty
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_cmd.opcode == OP_CLEAR |=> r_count == '0 && r_empty)
        else $error("list not empty after clear");

    // reported count follows the internal count
    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_fill == r_count)
        else $error("reported fill count differs from internal count");

endmodule
